// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the swept box trace RTL.
// No dependencies; included by the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SBST_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("swept box trace check failed");

// Next-cycle implication, disabled during reset.
`define SBST_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("swept box trace check failed");

`endif

// ===== hdl/sbst_pkg.sv =====
// Package for the swept box slab trace: formats, widths, codes and shared types.
// No dependencies; every other file but assert_macros.svh imports it.
`timescale 1ns / 1ps

package sbst_pkg;

   localparam int COORD_BITS    = 21;
   localparam int FRACTION_BITS = 16;
   localparam int WORD_W        = 63;
   // slab bound minus start, sign flipped: needs three bits over a coordinate
   localparam int WIDE_W        = COORD_BITS + 3;
   localparam int DIST_W        = COORD_BITS + 1;
   localparam int PROD_W        = WIDE_W + DIST_W + 1;
   localparam int SCALE_W       = FRACTION_BITS + 1 + DIST_W;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_MOVER_MIN = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MOVER_MAX = 1'b1;

   localparam logic [FRACTION_BITS:0] FRAC_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

   typedef enum logic [1:0] {
      OUT_MISS  = 2'd0,
      OUT_FREE  = 2'd1,
      OUT_SOLID = 2'd2,
      OUT_HIT   = 2'd3
   } outcome_type;

   typedef logic [1:0] axis_type;
   localparam axis_type AXIS_X = 2'd0;
   localparam axis_type AXIS_Z = 2'd2;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      outcome_type                   outcome;
      logic [DIST_W-1:0]             en_num;
      logic [DIST_W-1:0]             en_den;
      axis_type                      axis;
      logic                          neg;
      logic [2:0][COORD_BITS-1:0]    start;
      logic [2:0][DIST_W-1:0]        delta;
      logic [WORD_W-1:0]             end_word;
   } queue_item_type;

   function automatic logic signed [COORD_BITS-1:0] coord_of(input logic [WORD_W-1:0] w,
                                                             input int k);
      return $signed(w[k*COORD_BITS +: COORD_BITS]);
   endfunction

endpackage

// ===== hdl/sbst_req_if.sv =====
// Request channel of the swept box trace: segment and target box per word.
// Depends on sbst_pkg for the word width.
`timescale 1ns / 1ps

interface sbst_req_if import sbst_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] start_pos;
   logic [WORD_W-1:0] end_pos;
   logic [WORD_W-1:0] box_origin;
   logic [WORD_W-1:0] box_min_offset;
   logic [WORD_W-1:0] box_max_offset;

   modport source(output valid, start_pos, end_pos, box_origin, box_min_offset,
                  box_max_offset, input ready);
   modport sink(input valid, start_pos, end_pos, box_origin, box_min_offset,
                box_max_offset, output ready);
endinterface

// ===== hdl/sbst_rsp_if.sv =====
// Response channel of the swept box trace: outcome, fraction, face and stop point.
// Depends on sbst_pkg for the field widths.
`timescale 1ns / 1ps

interface sbst_rsp_if import sbst_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [1:0]               outcome;
   logic [FRACTION_BITS:0]   hit_fraction;
   logic [1:0]               face_axis;
   logic                     face_negative;
   logic [WORD_W-1:0]        stop_pos;

   modport source(output valid, outcome, hit_fraction, face_axis, face_negative, stop_pos,
                  input ready);
   modport sink(input valid, outcome, hit_fraction, face_axis, face_negative, stop_pos,
                output ready);
endinterface

// ===== hdl/swept_box_slab_trace_core.sv =====
// Top level of the swept box slab trace: mover registers, front, queue, back.
// Depends on sbst_pkg, both channel interfaces, sbst_front, sbst_queue, sbst_back.
//
//   channel   direction  handshake          carries
//   req_ch    in         valid/ready        segment ends, box centre and corner offsets
//   rsp_ch    out        valid/ready        outcome, fraction, entering face, stop point
//   csr_*     in         write enable only  mover minimum and maximum extents
//
// One word a cycle sustained while rsp_ch.ready stays high; the pipeline is 10 front stages,
// the queue and 19 back stages. The depth is set by the pipelined cross-multiply compare chain
// and the one-bit-per-stage fraction divider. Reset clears all valid flags, the queue
// and both mover registers. A stalled response fills the queue, then the front
// holds and req_ch.ready drops.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module swept_box_slab_trace_core import sbst_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   sbst_req_if.sink             req_ch,
   sbst_rsp_if.source           rsp_ch,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_wdata
);

   logic [WORD_W-1:0] mover_min_ff, mover_min_in;
   logic [WORD_W-1:0] mover_max_ff, mover_max_in;
   queue_status_type  q_status;
   queue_item_type    push_item;
   queue_item_type    pop_item;
   logic              push;
   logic              pop;
   logic              rsp_hit;
   logic              rsp_solid;
   logic              rsp_plain;

   always_comb begin
      mover_min_in = mover_min_ff;
      mover_max_in = mover_max_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MOVER_MIN: mover_min_in = csr_wdata;
            CSR_MOVER_MAX: mover_max_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mover_min_ff <= '0;
         mover_max_ff <= '0;
      end else begin
         mover_min_ff <= mover_min_in;
         mover_max_ff <= mover_max_in;
      end
   end

   sbst_front u_front (
      .clock     (clock),
      .reset     (reset),
      .mover_min (mover_min_ff),
      .mover_max (mover_max_ff),
      .req       (req_ch),
      .q_status  (q_status),
      .push      (push),
      .push_item (push_item)
   );

   sbst_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .status    (q_status)
   );

   sbst_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .pop_item (pop_item),
      .pop      (pop),
      .rsp      (rsp_ch)
   );

   assign rsp_hit   = rsp_ch.valid && (rsp_ch.outcome == OUT_HIT);
   assign rsp_solid = rsp_ch.valid && (rsp_ch.outcome == OUT_SOLID);
   assign rsp_plain = rsp_ch.valid &&
                      ((rsp_ch.outcome == OUT_MISS) || (rsp_ch.outcome == OUT_FREE));

   `SBST_ASSERT_IMP(a_no_push_full, clock, reset, push, !q_status.full)
   `SBST_ASSERT_IMP(a_hit_below_one, clock, reset, rsp_hit, !rsp_ch.hit_fraction[FRACTION_BITS])
   `SBST_ASSERT_IMP(a_solid_zero, clock, reset, rsp_solid, rsp_ch.hit_fraction == '0)
   `SBST_ASSERT_IMP(a_nohit_one, clock, reset, rsp_plain, rsp_ch.hit_fraction == FRAC_ONE)

endmodule

// ===== hdl/sbst_front.sv =====
// Front end: slab build, per-axis entry/exit tracking and outcome classification.
// Depends on sbst_pkg and sbst_req_if; pushes one classified word into the queue.
`timescale 1ns / 1ps

module sbst_front import sbst_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [WORD_W-1:0] mover_min,
   input  logic [WORD_W-1:0] mover_max,
   sbst_req_if.sink          req,
   input  queue_status_type  q_status,
   output logic              push,
   output queue_item_type    push_item
);

   typedef struct packed {
      logic              valid;
      logic [WORD_W-1:0] s;
      logic [WORD_W-1:0] e;
      logic [WORD_W-1:0] o;
      logic [WORD_W-1:0] mn;
      logic [WORD_W-1:0] mx;
   } raw_type;

   typedef struct packed {
      logic                       valid;
      logic [2:0][WIDE_W-1:0]     bmin;
      logic [2:0][WIDE_W-1:0]     bmax;
      logic [2:0][COORD_BITS-1:0] start;
      logic [2:0][DIST_W-1:0]     delta;
      logic [WORD_W-1:0]          end_word;
   } slab_type;

   typedef struct packed {
      logic                       valid;
      logic [2:0]                 dz;
      logic [2:0]                 par_out;
      logic [2:0]                 graze;
      logic [2:0]                 ins;
      logic [2:0]                 pos_dir;
      logic [2:0][WIDE_W-1:0]     lo;
      logic [2:0][WIDE_W-1:0]     hi;
      logic [2:0][DIST_W-1:0]     dd;
      logic [WIDE_W-1:0]          en_num;
      logic [DIST_W-1:0]          en_den;
      logic [WIDE_W-1:0]          ex_num;
      logic [DIST_W-1:0]          ex_den;
      axis_type                   axis;
      logic                       ax_valid;
      logic [PROD_W-1:0]          p_en;
      logic [PROD_W-1:0]          p_en_ref;
      logic [PROD_W-1:0]          p_ex;
      logic [PROD_W-1:0]          p_ex_ref;
      logic [2:0][COORD_BITS-1:0] start;
      logic [2:0][DIST_W-1:0]     delta;
      logic [WORD_W-1:0]          end_word;
   } track_type;

   localparam int TRACK_STAGES = 8;

   function automatic logic [PROD_W-1:0] smul(input logic signed [WIDE_W-1:0] a,
                                             input logic signed [DIST_W:0] b);
      logic signed [PROD_W-1:0] ae;
      logic signed [PROD_W-1:0] be;
      ae = a;
      be = b;
      return ae * be;
   endfunction

   function automatic track_type build_axes(input slab_type sl);
      track_type                t;
      logic signed [WIDE_W-1:0] bl;
      logic signed [WIDE_W-1:0] bh;
      logic signed [WIDE_W-1:0] tmp;
      logic signed [WIDE_W-1:0] sx;
      logic signed [WIDE_W-1:0] n1;
      logic signed [WIDE_W-1:0] n2;
      logic signed [DIST_W-1:0] d;
      t = '0;
      t.valid    = sl.valid;
      t.start    = sl.start;
      t.delta    = sl.delta;
      t.end_word = sl.end_word;
      for (int k = 0; k < 3; k++) begin
         bl = $signed(sl.bmin[k]);
         bh = $signed(sl.bmax[k]);
         if (bl > bh) begin
            tmp = bl;
            bl  = bh;
            bh  = tmp;
         end
         sx = WIDE_W'($signed(sl.start[k]));
         d  = $signed(sl.delta[k]);
         n1 = bl - sx;
         n2 = bh - sx;
         // moving backwards: flip so the denominator is positive
         if (d[DIST_W-1]) begin
            n1 = -n1;
            n2 = -n2;
         end
         t.lo[k]      = (n1 < n2) ? n1 : n2;
         t.hi[k]      = (n1 < n2) ? n2 : n1;
         t.dd[k]      = d[DIST_W-1] ? DIST_W'(-d) : DIST_W'(d);
         t.dz[k]      = (d == '0);
         t.par_out[k] = (d == '0) && ((sx < bl) || (sx > bh));
         t.graze[k]   = (d == '0) && ((sx == bl) || (sx == bh));
         t.ins[k]     = (sx > bl) && (sx < bh);
         t.pos_dir[k] = (d > 0);
      end
      t.en_num   = '0;
      t.en_den   = DIST_W'(1);
      t.ex_num   = WIDE_W'(1);
      t.ex_den   = DIST_W'(1);
      t.axis     = AXIS_Z;
      t.ax_valid = 1'b0;
      return t;
   endfunction

   function automatic track_type mul_step(input track_type t, input int k);
      track_type r;
      r = t;
      r.p_en     = smul($signed(t.lo[k]), $signed({1'b0, t.en_den}));
      r.p_en_ref = smul($signed(t.en_num), $signed({1'b0, t.dd[k]}));
      r.p_ex     = smul($signed(t.hi[k]), $signed({1'b0, t.ex_den}));
      r.p_ex_ref = smul($signed(t.ex_num), $signed({1'b0, t.dd[k]}));
      return r;
   endfunction

   function automatic track_type cmp_step(input track_type t, input int k);
      track_type r;
      r = t;
      if (!t.dz[k]) begin
         // ties go to the later axis
         if ($signed(t.p_en) >= $signed(t.p_en_ref)) begin
            r.en_num   = t.lo[k];
            r.en_den   = t.dd[k];
            r.axis     = axis_type'(k);
            r.ax_valid = 1'b1;
         end
         if ($signed(t.p_ex) < $signed(t.p_ex_ref)) begin
            r.ex_num = t.hi[k];
            r.ex_den = t.dd[k];
         end
      end
      return r;
   endfunction

   function automatic track_type final_mul(input track_type t);
      track_type r;
      r = t;
      r.p_en     = smul($signed(t.en_num), $signed({1'b0, t.ex_den}));
      r.p_en_ref = smul($signed(t.ex_num), $signed({1'b0, t.en_den}));
      return r;
   endfunction

   function automatic queue_item_type classify(input track_type t);
      queue_item_type q;
      q.en_num   = t.en_num[DIST_W-1:0];
      q.en_den   = t.en_den;
      q.axis     = t.ax_valid ? t.axis : AXIS_Z;
      q.neg      = t.ax_valid ? t.pos_dir[t.axis] : 1'b0;
      q.start    = t.start;
      q.delta    = t.delta;
      q.end_word = t.end_word;
      if (|t.par_out)
         q.outcome = OUT_MISS;
      else if ($signed(t.p_en) > $signed(t.p_en_ref))
         q.outcome = OUT_MISS;
      else if (&t.ins)
         q.outcome = OUT_SOLID;
      else if ($signed(t.ex_num) <= 0)
         q.outcome = OUT_FREE;
      else if (|t.graze)
         q.outcome = OUT_FREE;
      else if ($signed(t.en_num) >= $signed({1'b0, t.en_den}))
         q.outcome = OUT_FREE;
      else
         q.outcome = OUT_HIT;
      return q;
   endfunction

   raw_type   raw_ff, raw_in;
   slab_type  slab_ff, slab_in;
   track_type tr_ff [TRACK_STAGES];
   track_type tr_in [TRACK_STAGES];
   logic      adv;

   // the whole front advances together; hold while the queue is full
   assign adv       = !q_status.full;
   assign req.ready = adv;

   always_comb begin
      raw_in.valid = req.valid;
      raw_in.s     = req.start_pos;
      raw_in.e     = req.end_pos;
      raw_in.o     = req.box_origin;
      raw_in.mn    = req.box_min_offset;
      raw_in.mx    = req.box_max_offset;
   end

   always_comb begin
      logic signed [WIDE_W-1:0]   o;
      logic signed [WIDE_W-1:0]   lo_off;
      logic signed [WIDE_W-1:0]   hi_off;
      logic signed [WIDE_W-1:0]   mv_lo;
      logic signed [WIDE_W-1:0]   mv_hi;
      logic signed [DIST_W-1:0]   s;
      logic signed [DIST_W-1:0]   e;
      logic [3*COORD_BITS-1:0]    e_pack;
      slab_in       = '0;
      slab_in.valid = raw_ff.valid;
      e_pack        = '0;
      for (int k = 0; k < 3; k++) begin
         o      = coord_of(raw_ff.o, k);
         lo_off = coord_of(raw_ff.mn, k);
         hi_off = coord_of(raw_ff.mx, k);
         mv_lo  = coord_of(mover_min, k);
         mv_hi  = coord_of(mover_max, k);
         s      = coord_of(raw_ff.s, k);
         e      = coord_of(raw_ff.e, k);
         slab_in.bmin[k]  = o + lo_off - mv_hi;
         slab_in.bmax[k]  = o + hi_off - mv_lo;
         slab_in.start[k] = coord_of(raw_ff.s, k);
         slab_in.delta[k] = e - s;
         e_pack[k*COORD_BITS +: COORD_BITS] = coord_of(raw_ff.e, k);
      end
      slab_in.end_word = WORD_W'(e_pack);
   end

   assign tr_in[0] = build_axes(slab_ff);
   for (genvar k = 0; k < 3; k++) begin : g_axis
      assign tr_in[2*k+1] = mul_step(tr_ff[2*k], k);
      assign tr_in[2*k+2] = cmp_step(tr_ff[2*k+1], k);
   end
   assign tr_in[TRACK_STAGES-1] = final_mul(tr_ff[TRACK_STAGES-2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_ff.valid  <= 1'b0;
         slab_ff.valid <= 1'b0;
         for (int j = 0; j < TRACK_STAGES; j++)
            tr_ff[j].valid <= 1'b0;
      end else if (adv) begin
         raw_ff  <= raw_in;
         slab_ff <= slab_in;
         for (int j = 0; j < TRACK_STAGES; j++)
            tr_ff[j] <= tr_in[j];
      end
   end

   assign push      = adv && tr_ff[TRACK_STAGES-1].valid;
   assign push_item = classify(tr_ff[TRACK_STAGES-1]);

endmodule

// ===== hdl/sbst_queue.sv =====
// Short queue of classified words between the front and back ends.
// Depends on sbst_pkg for the word and status types.
`timescale 1ns / 1ps

module sbst_queue import sbst_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  queue_item_type   push_item,
   input  logic             pop,
   output queue_item_type   pop_item,
   output queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   queue_item_type   slots [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push)
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      if (pop)
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      if (push && !pop)
         count_in = count_ff + CNT_W'(1);
      else if (pop && !push)
         count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push)
         slots[wr_ptr_ff] <= push_item;
   end

   assign pop_item     = slots[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

// ===== hdl/sbst_back.sv =====
// Back end: entry fraction by restoring division, stop point and response register.
// Depends on sbst_pkg and sbst_rsp_if; pops classified words from the queue.
`timescale 1ns / 1ps

module sbst_back import sbst_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_status,
   input  queue_item_type   pop_item,
   output logic             pop,
   sbst_rsp_if.source       rsp
);

   typedef struct packed {
      logic                       valid;
      outcome_type                outcome;
      logic [DIST_W:0]            rem;
      logic [DIST_W-1:0]          den;
      logic [FRACTION_BITS-1:0]   quo;
      axis_type                   axis;
      logic                       neg;
      logic [2:0][COORD_BITS-1:0] start;
      logic [2:0][DIST_W-1:0]     delta;
      logic [WORD_W-1:0]          end_word;
   } div_type;

   typedef struct packed {
      logic                       valid;
      outcome_type                outcome;
      logic [FRACTION_BITS:0]     frac;
      axis_type                   axis;
      logic                       neg;
      logic [2:0][COORD_BITS-1:0] start;
      logic [2:0][SCALE_W-1:0]    prod;
      logic [WORD_W-1:0]          end_word;
   } scale_type;

   typedef struct packed {
      logic                   valid;
      outcome_type            outcome;
      logic [FRACTION_BITS:0] frac;
      axis_type               axis;
      logic                   neg;
      logic [WORD_W-1:0]      stop;
   } out_type;

   localparam int DIV_STAGES = FRACTION_BITS + 1;

   function automatic logic [SCALE_W-1:0] smul(input logic signed [FRACTION_BITS+1:0] a,
                                              input logic signed [DIST_W-1:0] b);
      logic signed [SCALE_W-1:0] ae;
      logic signed [SCALE_W-1:0] be;
      ae = a;
      be = b;
      return ae * be;
   endfunction

   function automatic div_type load(input queue_item_type q, input logic v);
      div_type t;
      t.valid    = v;
      t.outcome  = q.outcome;
      t.rem      = {1'b0, q.en_num};
      t.den      = q.en_den;
      t.quo      = '0;
      t.axis     = q.axis;
      t.neg      = q.neg;
      t.start    = q.start;
      t.delta    = q.delta;
      t.end_word = q.end_word;
      return t;
   endfunction

   // one quotient bit: remainder stays below the denominator
   function automatic div_type div_step(input div_type t);
      div_type         r;
      logic [DIST_W:0] r2;
      logic            q_bit;
      r     = t;
      r2    = {t.rem[DIST_W-1:0], 1'b0};
      q_bit = (r2 >= {1'b0, t.den});
      r.rem = q_bit ? (r2 - {1'b0, t.den}) : r2;
      r.quo = {t.quo[FRACTION_BITS-2:0], q_bit};
      return r;
   endfunction

   function automatic scale_type scale_step(input div_type t);
      scale_type s;
      s.valid    = t.valid;
      s.outcome  = t.outcome;
      s.axis     = t.axis;
      s.neg      = t.neg;
      s.start    = t.start;
      s.end_word = t.end_word;
      if (t.outcome == OUT_HIT)
         s.frac = {1'b0, t.quo};
      else if (t.outcome == OUT_SOLID)
         s.frac = '0;
      else
         s.frac = FRAC_ONE;
      for (int k = 0; k < 3; k++)
         s.prod[k] = smul($signed({2'b00, t.quo}), $signed(t.delta[k]));
      return s;
   endfunction

   function automatic out_type finish(input scale_type s);
      out_type                   o;
      logic signed [SCALE_W-1:0] sx;
      logic signed [SCALE_W-1:0] p;
      logic [3*COORD_BITS-1:0]   pack;
      pack      = '0;
      o.valid   = s.valid;
      o.outcome = s.outcome;
      o.frac    = s.frac;
      for (int k = 0; k < 3; k++) begin
         sx = SCALE_W'($signed(s.start[k]));
         p  = sx + ($signed(s.prod[k]) >>> FRACTION_BITS);
         pack[k*COORD_BITS +: COORD_BITS] = p[COORD_BITS-1:0];
      end
      if (s.outcome == OUT_HIT) begin
         o.axis = s.axis;
         o.neg  = s.neg;
         o.stop = WORD_W'(pack);
      end else begin
         o.axis = AXIS_X;
         o.neg  = 1'b0;
         o.stop = s.end_word;
      end
      return o;
   endfunction

   div_type   dv_ff [DIV_STAGES];
   div_type   dv_in [DIV_STAGES];
   scale_type sc_ff, sc_in;
   out_type   out_ff, out_in;
   logic      badv;

   // whole back end moves when the response register is free or being taken
   assign badv = !out_ff.valid || rsp.ready;
   assign pop  = badv && !q_status.empty;

   assign dv_in[0] = load(pop_item, pop);
   for (genvar j = 1; j < DIV_STAGES; j++) begin : g_div
      assign dv_in[j] = div_step(dv_ff[j-1]);
   end
   assign sc_in  = scale_step(dv_ff[DIV_STAGES-1]);
   assign out_in = finish(sc_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < DIV_STAGES; j++)
            dv_ff[j].valid <= 1'b0;
         sc_ff.valid  <= 1'b0;
         out_ff.valid <= 1'b0;
      end else if (badv) begin
         for (int j = 0; j < DIV_STAGES; j++)
            dv_ff[j] <= dv_in[j];
         sc_ff  <= sc_in;
         out_ff <= out_in;
      end
   end

   assign rsp.valid         = out_ff.valid;
   assign rsp.outcome       = out_ff.outcome;
   assign rsp.hit_fraction  = out_ff.frac;
   assign rsp.face_axis     = out_ff.axis;
   assign rsp.face_negative = out_ff.neg;
   assign rsp.stop_pos      = out_ff.stop;

endmodule

// ===== bench/sbst_trace_checker.sv =====
// Checker for the swept box slab trace: watches both channels and the mover registers.
// Predicts each response word from the request word and compares it field by field.
// Depends on sbst_pkg and the two channel interfaces.
`timescale 1ns / 1ps

module sbst_trace_checker import sbst_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   sbst_req_if                  req_ch,
   sbst_rsp_if                  rsp_ch,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_wdata,
   output int                   fail_count,
   output int                   pending
);

   typedef struct packed {
      logic [1:0]             outcome;
      logic [FRACTION_BITS:0] hit_fraction;
      logic [1:0]             face_axis;
      logic                   face_negative;
      logic [WORD_W-1:0]      stop_pos;
   } trace_result_type;

   logic [WORD_W-1:0] mover_min_q, mover_max_q;
   trace_result_type  trace_expected[$];

   function automatic longint lane(input logic [WORD_W-1:0] w, input int k);
      logic [COORD_BITS-1:0] c;
      c = w[k*COORD_BITS +: COORD_BITS];
      return longint'($signed(c));
   endfunction

   function automatic longint div_floor(input longint a, input longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && ((a < 0) != (b < 0))) q = q - 1;
      return q;
   endfunction

   function automatic trace_result_type plain_result(input logic [1:0] oc,
                                                     input logic [WORD_W-1:0] endw);
      trace_result_type r;
      r.outcome       = oc;
      r.hit_fraction  = (oc == OUT_SOLID) ? '0 : FRAC_ONE;
      r.face_axis     = AXIS_X;
      r.face_negative = 1'b0;
      r.stop_pos      = '0;
      r.stop_pos[3*COORD_BITS-1:0] = endw[3*COORD_BITS-1:0];
      return r;
   endfunction

   function automatic trace_result_type sweep_box(input logic [WORD_W-1:0] sw, ew, ow, lw, hw);
      longint s[3], e[3], lo_b[3], hi_b[3];
      longint en_n, en_d, ex_n, ex_d, d, n1, n2, lo, hi, t, frac, fone;
      int ent_axis;
      bit in_solid;
      trace_result_type r;
      fone = longint'(1) << FRACTION_BITS;
      en_n = 0; en_d = 1; ex_n = 1; ex_d = 1; ent_axis = -1; in_solid = 1;
      for (int i = 0; i < 3; i++) begin
         s[i] = lane(sw, i);
         e[i] = lane(ew, i);
         lo_b[i] = lane(ow, i) + lane(lw, i) - lane(mover_max_q, i);
         hi_b[i] = lane(ow, i) + lane(hw, i) - lane(mover_min_q, i);
         if (lo_b[i] > hi_b[i]) begin
            t = lo_b[i]; lo_b[i] = hi_b[i]; hi_b[i] = t;
         end
      end
      for (int i = 0; i < 3; i++) begin
         d = e[i] - s[i];
         if (d == 0) begin
            if (s[i] < lo_b[i] || s[i] > hi_b[i]) return plain_result(OUT_MISS, ew);
         end else begin
            n1 = lo_b[i] - s[i];
            n2 = hi_b[i] - s[i];
            if (d < 0) begin
               n1 = -n1; n2 = -n2; d = -d;
            end
            lo = (n1 < n2) ? n1 : n2;
            hi = (n1 < n2) ? n2 : n1;
            // later axis wins a tie on entry
            if (lo * en_d >= en_n * d) begin
               en_n = lo; en_d = d; ent_axis = i;
            end
            if (hi * ex_d < ex_n * d) begin
               ex_n = hi; ex_d = d;
            end
         end
      end
      if (en_n * ex_d > ex_n * en_d) return plain_result(OUT_MISS, ew);
      for (int i = 0; i < 3; i++)
         if (s[i] <= lo_b[i] || s[i] >= hi_b[i]) in_solid = 0;
      if (in_solid) return plain_result(OUT_SOLID, ew);
      if (ex_n <= 0) return plain_result(OUT_FREE, ew);
      for (int i = 0; i < 3; i++)
         if (e[i] == s[i] && (s[i] == lo_b[i] || s[i] == hi_b[i]))
            return plain_result(OUT_FREE, ew);
      if (en_n >= en_d) return plain_result(OUT_FREE, ew);
      frac = div_floor(en_n * fone, en_d);
      r.outcome       = OUT_HIT;
      r.hit_fraction  = frac[FRACTION_BITS:0];
      r.face_axis     = (ent_axis >= 0) ? ent_axis[1:0] : AXIS_Z;
      r.face_negative = (ent_axis >= 0) ? ((e[ent_axis] - s[ent_axis]) > 0) : 1'b0;
      r.stop_pos      = '0;
      for (int i = 0; i < 3; i++) begin
         t = s[i] + div_floor(frac * (e[i] - s[i]), fone);
         r.stop_pos[i*COORD_BITS +: COORD_BITS] = t[COORD_BITS-1:0];
      end
      return r;
   endfunction

   assign pending = trace_expected.size();

   always @(posedge clock) begin
      trace_result_type want, got;
      if (reset) begin
         mover_min_q <= '0;
         mover_max_q <= '0;
         fail_count  <= 0;
         trace_expected.delete();
      end else begin
         if (req_ch.valid && req_ch.ready)
            trace_expected.push_back(sweep_box(req_ch.start_pos, req_ch.end_pos,
               req_ch.box_origin, req_ch.box_min_offset, req_ch.box_max_offset));
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.outcome, rsp_ch.hit_fraction, rsp_ch.face_axis,
                    rsp_ch.face_negative, rsp_ch.stop_pos};
            if (trace_expected.size() == 0) begin
               $display("%0t: unexpected response word %h", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               want = trace_expected.pop_front();
               if (want.outcome != got.outcome || want.hit_fraction != got.hit_fraction ||
                   want.face_axis != got.face_axis ||
                   want.face_negative != got.face_negative ||
                   want.stop_pos != got.stop_pos) begin
                  $display("%0t: outcome exp %0d act %0d, fraction exp %h act %h", $time,
                           want.outcome, got.outcome, want.hit_fraction, got.hit_fraction);
                  $display("%0t: axis exp %0d act %0d, neg exp %0d act %0d", $time,
                           want.face_axis, got.face_axis, want.face_negative,
                           got.face_negative);
                  $display("%0t: stop exp %h act %h", $time, want.stop_pos, got.stop_pos);
                  fail_count <= fail_count + 1;
               end
            end
         end
         // mover registers take effect from the word after the write
         if (csr_we) begin
            if (csr_index == CSR_MOVER_MIN) mover_min_q <= csr_wdata;
            else if (csr_index == CSR_MOVER_MAX) mover_max_q <= csr_wdata;
         end
      end
   end

endmodule

// ===== bench/tb.sv =====
// Top of the swept box slab trace testbench: clock, reset, stimulus and verdict.
// Depends on sbst_pkg, both channel interfaces, the core and sbst_trace_checker.
`timescale 1ns / 1ps

module tb;
   import sbst_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 40;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [WORD_W-1:0]    csr_wdata;
   int                   fail_count;
   int                   pending;
   int                   idle_cycles;
   bit                   no_stall;
   int                   rsp_hold;

   sbst_req_if req_ch();
   sbst_rsp_if rsp_ch();

   swept_box_slab_trace_core i_dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   sbst_trace_checker i_checker (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending(pending)
   );

   always begin
      clock = 1'b0; #5;
      clock = 1'b1; #5;
   end

   function automatic logic [WORD_W-1:0] pack3(input int x, input int y, input int z);
      logic [WORD_W-1:0] w;
      w = '0;
      w[0 +: COORD_BITS]            = x[COORD_BITS-1:0];
      w[COORD_BITS +: COORD_BITS]   = y[COORD_BITS-1:0];
      w[2*COORD_BITS +: COORD_BITS] = z[COORD_BITS-1:0];
      return w;
   endfunction

   function automatic logic [WORD_W-1:0] any_word();
      return WORD_W'({$urandom, $urandom});
   endfunction

   function automatic int near(input int span);
      return $urandom_range(0, 2 * span) - span;
   endfunction

   function automatic logic [WORD_W-1:0] near_word(input int span);
      return pack3(near(span), near(span), near(span));
   endfunction

   // Response side: hold ready low for a drawn number of cycles per word
   always @(posedge clock) begin
      int hold_next;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_hold     <= 0;
      end else begin
         hold_next = rsp_hold;
         if (rsp_ch.valid && rsp_ch.ready)
            hold_next = no_stall ? 0 : $urandom_range(0, 9);
         else if (hold_next > 0)
            hold_next = hold_next - 1;
         rsp_hold     <= hold_next;
         rsp_ch.ready <= (hold_next == 0);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   task automatic send_word(input logic [WORD_W-1:0] s, e, o, lo, hi);
      int gap;
      gap = no_stall ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.start_pos      <= s;
      req_ch.end_pos        <= e;
      req_ch.box_origin     <= o;
      req_ch.box_min_offset <= lo;
      req_ch.box_max_offset <= hi;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // Drain, then write both mover registers on consecutive edges
   task automatic set_mover(input logic [WORD_W-1:0] mn, input logic [WORD_W-1:0] mx);
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_MOVER_MIN;
      csr_wdata <= mn;
      @(posedge clock);
      csr_index <= CSR_MOVER_MAX;
      csr_wdata <= mx;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic random_words(input int count, input int span);
      logic [WORD_W-1:0] o;
      int u;
      for (int n = 0; n < count; n++) begin
         u = $urandom_range(0, 9);
         o = near_word(span / 2);
         if (u < 2)
            send_word(any_word(), any_word(), any_word(), any_word(), any_word());
         else if (u == 2)
            // swapped corners
            send_word(near_word(span), near_word(span), o, near_word(span / 4),
                      pack3(-near(span / 4), 0, near(span / 4)));
         else if (u == 3)
            // motion along fewer axes, start on a bound or parallel
            send_word(pack3(near(span), 1024, 0), pack3(near(span), 1024, 0),
                      pack3(0, 0, 0), pack3(-1024, -1024, -1024), pack3(1024, 1024, 1024));
         else
            send_word(near_word(span), near_word(span), o,
                      pack3(-$urandom_range(0, span / 4), -$urandom_range(0, span / 4),
                            -$urandom_range(0, span / 4)),
                      pack3($urandom_range(0, span / 4), $urandom_range(0, span / 4),
                            $urandom_range(0, span / 4)));
      end
   endtask

   initial begin
      logic [WORD_W-1:0] bmin, bmax, zero_w, ones_w, maxp_w, minn_w;
      reset                 <= 1'b1;
      csr_we                <= 1'b0;
      csr_index             <= CSR_MOVER_MIN;
      csr_wdata             <= '0;
      no_stall              <= 1'b0;
      req_ch.valid          <= 1'b0;
      req_ch.start_pos      <= '0;
      req_ch.end_pos        <= '0;
      req_ch.box_origin     <= '0;
      req_ch.box_min_offset <= '0;
      req_ch.box_max_offset <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      bmin   = pack3(-1024, -1024, -1024);
      bmax   = pack3(1024, 1024, 1024);
      zero_w = '0;
      ones_w = '1;
      maxp_w = pack3((1 << (COORD_BITS - 1)) - 1, (1 << (COORD_BITS - 1)) - 1,
                     (1 << (COORD_BITS - 1)) - 1);
      minn_w = pack3(-(1 << (COORD_BITS - 1)), -(1 << (COORD_BITS - 1)),
                     -(1 << (COORD_BITS - 1)));

      // directed words with zero mover extents
      send_word(pack3(-2048, 0, 0), pack3(2048, 0, 0), zero_w, bmin, bmax);
      send_word(pack3(2048, 0, 0), pack3(-2048, 0, 0), zero_w, bmin, bmax);
      send_word(pack3(0, -2048, 0), pack3(0, 2048, 0), zero_w, bmin, bmax);
      send_word(pack3(0, 2048, 0), pack3(0, -2048, 0), zero_w, bmin, bmax);
      send_word(pack3(0, 0, -2048), pack3(0, 0, 2048), zero_w, bmin, bmax);
      send_word(pack3(0, 0, 2048), pack3(0, 0, -2048), zero_w, bmin, bmax);
      send_word(pack3(-2048, 5000, 0), pack3(2048, 5000, 0), zero_w, bmin, bmax);
      send_word(pack3(-3000, 0, 0), pack3(0, 3000, 0), zero_w, bmin, bmax);
      send_word(pack3(0, 0, 0), pack3(300, 20, 0), zero_w, bmin, bmax);
      send_word(pack3(2048, 0, 0), pack3(4096, 0, 0), zero_w, bmin, bmax);
      send_word(pack3(-2048, 1024, 0), pack3(2048, 1024, 0), zero_w, bmin, bmax);
      send_word(pack3(-4096, 0, 0), pack3(-2048, 0, 0), zero_w, bmin, bmax);
      send_word(pack3(-2048, -2048, 0), pack3(2048, 2048, 0), zero_w, bmin, bmax);
      send_word(pack3(-2048, 0, 0), pack3(2048, 0, 0), zero_w, bmax, bmin);
      send_word(pack3(-1024, 0, 0), pack3(2048, 0, 0), zero_w, bmin, bmax);
      send_word(pack3(0, 0, 0), pack3(0, 0, 0), zero_w, zero_w, zero_w);
      send_word(ones_w, ones_w, ones_w, ones_w, ones_w);
      send_word(maxp_w, minn_w, maxp_w, minn_w, maxp_w);
      send_word(minn_w, maxp_w, minn_w, maxp_w, minn_w);
      send_word(maxp_w, minn_w, zero_w, minn_w, maxp_w);

      no_stall <= 1'b1;
      random_words(180, 8192);
      no_stall <= 1'b0;
      set_mover(pack3(-256, -512, -128), pack3(256, 512, 128));
      random_words(180, 8192);
      set_mover(ones_w, ones_w);
      random_words(180, 8192);
      set_mover(minn_w, maxp_w);
      random_words(180, 1 << 20);
      set_mover(any_word(), any_word());
      random_words(180, 1 << 20);

      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule
